FILE: hw/rtl/midpoint_circle_generator_defines.svh
// Assertion macros used by the circle generator RTL.
`ifndef MIDPOINT_CIRCLE_GENERATOR_DEFINES_SVH
`define MIDPOINT_CIRCLE_GENERATOR_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define MCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never occurs.
`define MCG_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/mcg_pkg.sv
// Constants and types for the midpoint circle generator.
package mcg_pkg;

    localparam int COORD_BITS = 12;
    localparam int RAD_W      = COORD_BITS + 1;          // radius and step width
    localparam int SQ_W       = 2 * COORD_BITS + 2;      // squared distance, even
    localparam int REM_W      = RAD_W + 3;               // square root remainder
    localparam int CNT_W      = $clog2(RAD_W + 1);
    localparam int DEC_W      = 16;
    localparam int PIX_W      = 15;
    localparam int RGB_W      = 24;
    localparam int OCT_W      = 3;

    localparam int IN_FIELDS_W  = 4 * COORD_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * PIX_W + RGB_W + OCT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PIXEL_COLOUR = 1'b0;

    localparam logic [DEC_W-1:0] DEC_INIT    = DEC_W'(1);
    localparam logic [DEC_W-1:0] DEC_INC_NEG = DEC_W'(3);
    localparam logic [DEC_W-1:0] DEC_INC_POS = DEC_W'(5);

    localparam logic [OCT_W-1:0] OCT_LAST = '1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

FILE: hw/rtl/midpoint_circle_generator.sv
// Midpoint circle rasterizer: serial radius search and eight-way pixel emission.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid/s_tready   | s_tdata: centre, edge point; s_tuser: req type
//  m_*     | out | m_tvalid/m_tready   | m_tdata: pixel, colour, octant; tuser/tlast
//  apb     | in  | psel/penable/pready | pixel_colour register at address 0
//
// Start word: shift-add squaring of dx and dy, then the two-bit-per-cycle
//   restoring square root that yields the radius.
// Advance word: eight pixels, one per cycle from the output register while
//   m_tready is high; no pixels when no circle is active.
// s_tready is high only between words; m_* is held while m_tready is low.
// Reset clears all control state and the colour register; no clearing pass.
`include "midpoint_circle_generator_defines.svh"

module midpoint_circle_generator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x, center_y, edge_x, edge_y
    input  logic [mcg_pkg::IN_TDATA_W-1:0]      s_tdata,
    // req_type
    input  logic [0:0]                          s_tuser,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, pixel_rgb, octant_index, zero fill
    output logic [mcg_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // last_of_step
    output logic [0:0]                          m_tuser,
    // last_of_circle
    output logic                                m_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mcg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mcg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CB = mcg_pkg::COORD_BITS;

    mcg_pkg::state_t                  state_reg, state_next;
    logic [mcg_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [mcg_pkg::RGB_W-1:0]        colour_reg, colour_next;

    logic [CB-1:0]                    centre_x_reg, centre_x_next;
    logic [CB-1:0]                    centre_y_reg, centre_y_next;
    logic [mcg_pkg::RAD_W-1:0]        step_x_reg, step_x_next;
    logic [mcg_pkg::RAD_W-1:0]        step_y_reg, step_y_next;
    logic [mcg_pkg::DEC_W-1:0]        decision_reg, decision_next;
    logic                             drawing_reg, drawing_next;

    // squaring: multiplicands shift up, multipliers shift down
    logic [mcg_pkg::SQ_W-1:0]         mcand_x_reg, mcand_x_next;
    logic [mcg_pkg::SQ_W-1:0]         mcand_y_reg, mcand_y_next;
    logic [CB-1:0]                    mplier_x_reg, mplier_x_next;
    logic [CB-1:0]                    mplier_y_reg, mplier_y_next;
    // accumulator, then radicand shift register
    logic [mcg_pkg::SQ_W-1:0]         acc_reg, acc_next;
    logic [mcg_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [mcg_pkg::RAD_W-1:0]        root_reg, root_next;

    // emission
    logic [mcg_pkg::RAD_W-1:0]        emit_x_reg, emit_x_next;
    logic [mcg_pkg::RAD_W-1:0]        emit_y_reg, emit_y_next;
    logic                             done_reg, done_next;
    logic [mcg_pkg::OCT_W-1:0]        oct_reg, oct_next;

    // output register
    logic                             out_valid_reg, out_valid_next;
    logic [mcg_pkg::PIX_W-1:0]        pix_x_reg, pix_x_next;
    logic [mcg_pkg::PIX_W-1:0]        pix_y_reg, pix_y_next;
    logic [mcg_pkg::RGB_W-1:0]        rgb_reg, rgb_next;
    logic [mcg_pkg::OCT_W-1:0]        oct_out_reg, oct_out_next;
    logic                             last_step_reg, last_step_next;
    logic                             last_circ_reg, last_circ_next;

    logic [CB-1:0]                    in_cx, in_cy, in_ex, in_ey, dx, dy;
    logic                             in_accept, cfg_write, cnt_last, out_load;
    logic [mcg_pkg::SQ_W-1:0]         acc_sum;
    logic [mcg_pkg::REM_W-1:0]        rem_sh, trial;
    logic                             dec_ge;
    logic signed [mcg_pkg::RAD_W+1:0] nx_s, ny_s;
    logic [mcg_pkg::DEC_W-1:0]        x2, y2;
    logic [mcg_pkg::RAD_W-1:0]        sel_a, sel_b;
    logic [mcg_pkg::PIX_W-1:0]        cx15, cy15, a15, b15;
    logic                             neg_x, neg_y;

    assign in_cx = s_tdata[CB-1:0];
    assign in_cy = s_tdata[2*CB-1:CB];
    assign in_ex = s_tdata[3*CB-1:2*CB];
    assign in_ey = s_tdata[4*CB-1:3*CB];
    assign dx    = (in_cx > in_ex) ? in_cx - in_ex : in_ex - in_cx;
    assign dy    = (in_cy > in_ey) ? in_cy - in_ey : in_ey - in_cy;

    assign s_tready  = (state_reg == mcg_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cnt_last  = (cnt_reg == mcg_pkg::CNT_W'(1));
    assign out_load  = (state_reg == mcg_pkg::ST_EMIT) && (!out_valid_reg || m_tready);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == mcg_pkg::REG_PIXEL_COLOUR);
    assign prdata    = (paddr[2] == mcg_pkg::REG_PIXEL_COLOUR)
                       ? mcg_pkg::APB_DATA_W'(colour_reg) : '0;

    // one shift-add partial product for each of dx*dx and dy*dy
    assign acc_sum = acc_reg + (mplier_x_reg[0] ? mcand_x_reg : '0)
                             + (mplier_y_reg[0] ? mcand_y_reg : '0);

    // restoring square root: bring down two bits, try root*4+1
    assign rem_sh = {rem_reg[mcg_pkg::REM_W-3:0], acc_reg[mcg_pkg::SQ_W-1 -: 2]};
    assign trial  = mcg_pkg::REM_W'({root_reg, 2'b01});

    // decision and end test of the current step
    assign dec_ge = !decision_reg[mcg_pkg::DEC_W-1];
    assign x2     = mcg_pkg::DEC_W'({step_x_reg, 1'b0});
    assign y2     = mcg_pkg::DEC_W'({step_y_reg, 1'b0});
    assign nx_s   = $signed({2'b00, step_x_reg}) + 1;
    assign ny_s   = $signed({2'b00, step_y_reg})
                    - $signed({{(mcg_pkg::RAD_W + 1){1'b0}}, dec_ge});

    // octant mirror: upper four swap x and y
    assign neg_x = oct_reg[0] ^ oct_reg[1];
    assign neg_y = !(oct_reg[0] ^ oct_reg[2]);
    assign sel_a = oct_reg[2] ? emit_y_reg : emit_x_reg;
    assign sel_b = oct_reg[2] ? emit_x_reg : emit_y_reg;
    assign cx15  = mcg_pkg::PIX_W'(centre_x_reg);
    assign cy15  = mcg_pkg::PIX_W'(centre_y_reg);
    assign a15   = mcg_pkg::PIX_W'(sel_a);
    assign b15   = mcg_pkg::PIX_W'(sel_b);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        colour_next    = colour_reg;
        centre_x_next  = centre_x_reg;
        centre_y_next  = centre_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        decision_next  = decision_reg;
        drawing_next   = drawing_reg;
        mcand_x_next   = mcand_x_reg;
        mcand_y_next   = mcand_y_reg;
        mplier_x_next  = mplier_x_reg;
        mplier_y_next  = mplier_y_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        emit_x_next    = emit_x_reg;
        emit_y_next    = emit_y_reg;
        done_next      = done_reg;
        oct_next       = oct_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        rgb_next       = rgb_reg;
        oct_out_next   = oct_out_reg;
        last_step_next = last_step_reg;
        last_circ_next = last_circ_reg;

        if (cfg_write)
        begin
            colour_next = pwdata[mcg_pkg::RGB_W-1:0];
        end

        case (state_reg)
            mcg_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_tuser[0] == mcg_pkg::REQ_START)
                    begin
                        centre_x_next = in_cx;
                        centre_y_next = in_cy;
                        mcand_x_next  = mcg_pkg::SQ_W'(dx);
                        mcand_y_next  = mcg_pkg::SQ_W'(dy);
                        mplier_x_next = dx;
                        mplier_y_next = dy;
                        acc_next      = '0;
                        cnt_next      = mcg_pkg::CNT_W'(CB);
                        state_next    = mcg_pkg::ST_MUL;
                    end
                    else if (drawing_reg)
                    begin
                        emit_x_next = step_x_reg;
                        emit_y_next = step_y_reg;
                        if (dec_ge)
                        begin
                            decision_next = decision_reg + x2 - y2 + mcg_pkg::DEC_INC_POS;
                            step_y_next   = step_y_reg - mcg_pkg::RAD_W'(1);
                        end
                        else
                        begin
                            decision_next = decision_reg + x2 + mcg_pkg::DEC_INC_NEG;
                        end
                        step_x_next  = step_x_reg + mcg_pkg::RAD_W'(1);
                        done_next    = (nx_s > ny_s);
                        drawing_next = !(nx_s > ny_s);
                        oct_next     = '0;
                        state_next   = mcg_pkg::ST_EMIT;
                    end
                end
            end
            mcg_pkg::ST_MUL:
            begin
                acc_next      = acc_sum;
                mcand_x_next  = {mcand_x_reg[mcg_pkg::SQ_W-2:0], 1'b0};
                mcand_y_next  = {mcand_y_reg[mcg_pkg::SQ_W-2:0], 1'b0};
                mplier_x_next = {1'b0, mplier_x_reg[CB-1:1]};
                mplier_y_next = {1'b0, mplier_y_reg[CB-1:1]};
                cnt_next      = cnt_reg - mcg_pkg::CNT_W'(1);
                if (cnt_last)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = mcg_pkg::CNT_W'(mcg_pkg::RAD_W);
                    state_next = mcg_pkg::ST_SQRT;
                end
            end
            mcg_pkg::ST_SQRT:
            begin
                acc_next = {acc_reg[mcg_pkg::SQ_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[mcg_pkg::RAD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[mcg_pkg::RAD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - mcg_pkg::CNT_W'(1);
                if (cnt_last)
                begin
                    step_x_next   = '0;
                    step_y_next   = root_next;
                    decision_next = mcg_pkg::DEC_INIT - mcg_pkg::DEC_W'(root_next);
                    drawing_next  = 1'b1;
                    state_next    = mcg_pkg::ST_IDLE;
                end
            end
            mcg_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    pix_x_next     = neg_x ? cx15 - a15 : cx15 + a15;
                    pix_y_next     = neg_y ? cy15 - b15 : cy15 + b15;
                    rgb_next       = colour_reg;
                    oct_out_next   = oct_reg;
                    last_step_next = (oct_reg == mcg_pkg::OCT_LAST);
                    last_circ_next = (oct_reg == mcg_pkg::OCT_LAST) && done_reg;
                    oct_next       = oct_reg + mcg_pkg::OCT_W'(1);
                    if (oct_reg == mcg_pkg::OCT_LAST)
                    begin
                        state_next = mcg_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            colour_reg    <= '0;
            centre_x_reg  <= '0;
            centre_y_reg  <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            decision_reg  <= '0;
            drawing_reg   <= 1'b0;
            oct_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            colour_reg    <= colour_next;
            centre_x_reg  <= centre_x_next;
            centre_y_reg  <= centre_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            decision_reg  <= decision_next;
            drawing_reg   <= drawing_next;
            oct_reg       <= oct_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_x_reg   <= mcand_x_next;
        mcand_y_reg   <= mcand_y_next;
        mplier_x_reg  <= mplier_x_next;
        mplier_y_reg  <= mplier_y_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        emit_x_reg    <= emit_x_next;
        emit_y_reg    <= emit_y_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        rgb_reg       <= rgb_next;
        oct_out_reg   <= oct_out_next;
        last_step_reg <= last_step_next;
        last_circ_reg <= last_circ_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = mcg_pkg::OUT_TDATA_W'({oct_out_reg, rgb_reg, pix_y_reg, pix_x_reg});
    assign m_tuser[0] = last_step_reg;
    assign m_tlast    = last_circ_reg;

    `MCG_NEVER(a_circ_needs_step, m_tvalid && m_tlast && !m_tuser[0],
        "last pixel of circle not flagged as last of step")
    `MCG_ASSERT(a_emit_back_to_idle,
        (state_reg == mcg_pkg::ST_EMIT) && out_load && (oct_reg == mcg_pkg::OCT_LAST)
        |=> (state_reg == mcg_pkg::ST_IDLE),
        "emission did not end after eighth pixel")
    `MCG_ASSERT(a_octant_sequence,
        m_tvalid && m_tready && !m_tuser[0]
        |=> m_tvalid && (oct_out_reg == mcg_pkg::OCT_W'($past(oct_out_reg) + 1'b1)),
        "octant sequence broken within a step")

endmodule
